### design/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

	// Fixed field widths
	localparam int WORD_W  = 32;                 // coordinate word, signed
	localparam int STEP_W  = 29;                 // step registers, unsigned
	localparam int COUNT_W = 16;                 // iteration count
	localparam int PIX_W   = 12;                 // pixel coordinates
	localparam int IDX_W   = 3;                  // register index
	localparam int POS_W   = 17;                 // holds an image bound up to 65536
	localparam int MUL_W   = WORD_W + 1;         // signed multiplier operand
	localparam int PROD_W  = 64;                 // kept product width
	localparam int SUM_W   = PROD_W + 2;         // headroom for add before saturate

	// Parameter defaults
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_FRAC_BITS  = 28;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_ORIGIN_REAL    = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_IMAG    = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEP_REAL      = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_IMAG      = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

	// Register reset values
	localparam logic [WORD_W-1:0]  RST_ORIGIN_REAL    = 32'hE000_0000;
	localparam logic [WORD_W-1:0]  RST_ORIGIN_IMAG    = 32'h1000_0000;
	localparam logic [STEP_W-1:0]  RST_STEP_REAL      = 29'd196608;
	localparam logic [STEP_W-1:0]  RST_STEP_IMAG      = 29'd131072;
	localparam logic [COUNT_W-1:0] RST_MAX_ITERATIONS = 16'd256;

	typedef struct packed {
		logic [WORD_W-1:0]  origin_real;
		logic [WORD_W-1:0]  origin_imag;
		logic [STEP_W-1:0]  step_real;
		logic [STEP_W-1:0]  step_imag;
		logic [COUNT_W-1:0] max_iterations;
	} mbe_cfg_t;

	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
	} mbe_res_t;

	// Clamp a wide signed sum to the signed word range.
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-WORD_W:0] top;
		top = v[SUM_W-1:WORD_W-1];
		if ((&top) || !(|top))
			return $signed(v[WORD_W-1:0]);
		else if (v[SUM_W-1])
			return $signed({1'b1, {(WORD_W-1){1'b0}}});
		else
			return $signed({1'b0, {(WORD_W-1){1'b1}}});
	endfunction

endpackage

### design/mbe_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module mbe_mul (
	input  logic                                 clk,
	input  logic signed [mbe_pkg::MUL_W-1:0]     op_a,
	input  logic signed [mbe_pkg::MUL_W-1:0]     op_b,
	output logic signed [mbe_pkg::PROD_W-1:0]    prod_q
);

	logic signed [2*mbe_pkg::MUL_W-1:0] full;

	assign full = op_a * op_b;

	always_ff @(posedge clk) begin
		prod_q <= $signed(full[mbe_pkg::PROD_W-1:0]);
	end

endmodule

### design/mbe_core.sv
`timescale 1ns / 1ps

// Sequencer and datapath for one pixel: forms c, then runs z = z*z + c
// on the shared multiplier, three products per iteration.
module mbe_core #(
	parameter int MAX_WIDTH  = mbe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mbe_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mbe_pkg::PIX_W-1:0]     pixel_x,
	input  logic [mbe_pkg::PIX_W-1:0]     pixel_y,
	input  mbe_pkg::mbe_cfg_t             cfg,
	output logic                          ready,
	output mbe_pkg::mbe_res_t             res,
	input  logic                          res_ready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_C0   = 3'd1;
	localparam logic [2:0] ST_C1   = 3'd2;
	localparam logic [2:0] ST_C2   = 3'd3;
	localparam logic [2:0] ST_I0   = 3'd4;
	localparam logic [2:0] ST_I1   = 3'd5;
	localparam logic [2:0] ST_I2   = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam logic [mbe_pkg::PROD_W-1:0] ESC_LIM =
		(ESC_SHIFT < mbe_pkg::PROD_W) ? (64'd1 << ESC_SHIFT) : '1;
	localparam logic [mbe_pkg::POS_W-1:0] LIM_X = mbe_pkg::POS_W'(MAX_WIDTH);
	localparam logic [mbe_pkg::POS_W-1:0] LIM_Y = mbe_pkg::POS_W'(MAX_HEIGHT);

	logic [2:0]                             state_q;
	logic                                   updb_q;
	logic [mbe_pkg::PIX_W-1:0]              px_q, py_q;
	logic signed [mbe_pkg::WORD_W-1:0]      cr_q, ci_q, a_q, b_q;
	logic signed [mbe_pkg::PROD_W-1:0]      a2_q;
	logic [mbe_pkg::COUNT_W-1:0]            i_q, count_q;

	logic signed [mbe_pkg::MUL_W-1:0]       op_a, op_b;
	logic signed [mbe_pkg::PROD_W-1:0]      prod_q;
	logic signed [mbe_pkg::PROD_W:0]        diff;
	logic signed [mbe_pkg::SUM_W-1:0]       na_sum, nb_sum, cr_sum, ci_sum;
	logic [mbe_pkg::PROD_W-1:0]             modulus;
	logic                                   escaped, skip;
	logic [mbe_pkg::COUNT_W-1:0]            i_next;

	mbe_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// Operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_C0: begin
				op_a = $signed(mbe_pkg::MUL_W'(px_q));
				op_b = $signed(mbe_pkg::MUL_W'(cfg.step_real));
			end
			ST_C1: begin
				op_a = $signed(mbe_pkg::MUL_W'(py_q));
				op_b = $signed(mbe_pkg::MUL_W'(cfg.step_imag));
			end
			ST_I0: begin
				op_a = mbe_pkg::MUL_W'(a_q);
				op_b = mbe_pkg::MUL_W'(a_q);
			end
			ST_I1: begin
				op_a = mbe_pkg::MUL_W'(b_q);
				op_b = mbe_pkg::MUL_W'(b_q);
			end
			default: begin
				op_a = mbe_pkg::MUL_W'(a_q);
				op_b = mbe_pkg::MUL_W'(b_q);
			end
		endcase
	end

	// In ST_I2 prod_q holds b*b; in ST_I0 after an iteration it holds a*b.
	assign cr_sum  = mbe_pkg::SUM_W'($signed(cfg.origin_real)) + mbe_pkg::SUM_W'(prod_q);
	assign ci_sum  = mbe_pkg::SUM_W'($signed(cfg.origin_imag)) - mbe_pkg::SUM_W'(prod_q);
	assign diff    = (mbe_pkg::PROD_W + 1)'(a2_q) - (mbe_pkg::PROD_W + 1)'(prod_q);
	assign na_sum  = mbe_pkg::SUM_W'(diff >>> FRAC_BITS) + mbe_pkg::SUM_W'(cr_q);
	assign nb_sum  = mbe_pkg::SUM_W'(prod_q >>> (FRAC_BITS - 1)) + mbe_pkg::SUM_W'(ci_q);
	assign modulus = $unsigned(a2_q) + $unsigned(prod_q);
	assign escaped = modulus > ESC_LIM;
	assign i_next  = i_q + 1'b1;
	assign skip    = (mbe_pkg::POS_W'(pixel_x) >= LIM_X) || (mbe_pkg::POS_W'(pixel_y) >= LIM_Y)
		|| (cfg.max_iterations == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			updb_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= skip ? ST_FIN : ST_C0;
					end
				end
				ST_C0:   state_q <= ST_C1;
				ST_C1:   state_q <= ST_C2;
				ST_C2: begin
					updb_q  <= 1'b0;
					state_q <= ST_I0;
				end
				ST_I0:   state_q <= ST_I1;
				ST_I1:   state_q <= ST_I2;
				ST_I2: begin
					updb_q <= 1'b1;
					if (escaped || (i_next == cfg.max_iterations))
						state_q <= ST_FIN;
					else
						state_q <= ST_I0;
				end
				ST_FIN: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q    <= pixel_x;
				py_q    <= pixel_y;
				count_q <= '0;
			end
			ST_C1: cr_q <= mbe_pkg::sat_word(cr_sum);
			ST_C2: begin
				ci_q <= mbe_pkg::sat_word(ci_sum);
				a_q  <= '0;
				b_q  <= '0;
				i_q  <= '0;
			end
			ST_I0: begin
				if (updb_q)
					b_q <= mbe_pkg::sat_word(nb_sum);
			end
			ST_I1: a2_q <= prod_q;
			ST_I2: begin
				if (escaped)
					count_q <= i_q;
				a_q <= mbe_pkg::sat_word(na_sum);
				i_q <= i_next;
			end
			default: ;
		endcase
	end

	assign ready     = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_FIN);
	assign res.count = count_q;

endmodule

### design/mandelbrot_escape_time.sv
`timescale 1ns / 1ps

// Escape-time evaluator for one pixel of a fractal image.
// Input channel (in_valid/in_ready) takes one word: pixel_x, pixel_y.
// Output channel (out_valid/out_ready) returns one word: escape_count, the
// first iteration at which |z|^2 exceeds 4, or 0 if the point stays bounded,
// the pixel lies outside the image, or max_iterations is 0.
// Configure through cfg_we/cfg_index/cfg_data while no pixel is in flight;
// writes take effect at once, indexes past max_iterations are dropped.
// Each pixel runs its iterations (the escape index plus one, or
// max_iterations) on the single 33x33 multiplier, which forms a*a, b*b and
// a*b in turn. Pixels outside the image or with a zero limit skip the
// iterations: the core goes from idle straight to its result state. With the
// receiver ready, the next pixel can be taken in the cycle after the result
// leaves the core.
// One pixel is processed at a time; in_ready is low meanwhile.
// The result lands in an output register, so a new pixel is accepted while
// the previous result waits. If the receiver stalls and a second result is
// finished, the core holds it and stops taking input until the slot frees.
// Reset (arst_n low) restores the register defaults and drops any pixel
// in flight and any unread result.
module mandelbrot_escape_time #(
	parameter int MAX_WIDTH  = mbe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mbe_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mbe_pkg::PIX_W-1:0]      pixel_x,
	input  logic [mbe_pkg::PIX_W-1:0]      pixel_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mbe_pkg::COUNT_W-1:0]    escape_count,
	input  logic                           cfg_we,
	input  logic [mbe_pkg::IDX_W-1:0]      cfg_index,
	input  logic [mbe_pkg::WORD_W-1:0]     cfg_data
);

	mbe_pkg::mbe_cfg_t             cfg_q;
	mbe_pkg::mbe_res_t             res;
	logic                          core_ready;
	logic                          res_ready;
	logic                          out_valid_q;
	logic [mbe_pkg::COUNT_W-1:0]   escape_count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real    <= mbe_pkg::RST_ORIGIN_REAL;
			cfg_q.origin_imag    <= mbe_pkg::RST_ORIGIN_IMAG;
			cfg_q.step_real      <= mbe_pkg::RST_STEP_REAL;
			cfg_q.step_imag      <= mbe_pkg::RST_STEP_IMAG;
			cfg_q.max_iterations <= mbe_pkg::RST_MAX_ITERATIONS;
		end else if (cfg_we) begin
			case (cfg_index)
				mbe_pkg::REG_ORIGIN_REAL:    cfg_q.origin_real <= cfg_data;
				mbe_pkg::REG_ORIGIN_IMAG:    cfg_q.origin_imag <= cfg_data;
				mbe_pkg::REG_STEP_REAL:      cfg_q.step_real   <= cfg_data[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_STEP_IMAG:      cfg_q.step_imag   <= cfg_data[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_MAX_ITERATIONS:
					cfg_q.max_iterations <= cfg_data[mbe_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	mbe_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg       (cfg_q),
		.ready     (core_ready),
		.res       (res),
		.res_ready (res_ready)
	);

	assign in_ready = core_ready;

	// Output register: take a finished result when the slot is empty or draining.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready)
			escape_count_q <= res.count;
	end

	assign out_valid    = out_valid_q;
	assign escape_count = escape_count_q;

	// A pixel is taken only by an idle core, so ready drops right after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("core took a pixel while still busy");

	// The core cannot be idle and offering a result at once.
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(core_ready && res.valid))
		else $error("idle core presents a result");

	// Each new output word comes from a finished core result.
	a_out_from_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res.valid))
		else $error("output word appeared without a core result");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Checks the escape-time evaluator one pixel word at a time.
// Each accepted pixel word is run through a fixed-point predictor at the
// configured origin, step and iteration limit. The predicted escape_count is
// queued, and every result word is checked against the oldest entry.
module tb;

	localparam int FRAC = mbe_pkg::DEF_FRAC_BITS;
	// |z|^2 is kept with 2*FRAC fraction bits, so 4.0 sits at 4 << (2*FRAC)
	localparam longint unsigned ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC);
	localparam longint WORD_MAX = (64'sd1 <<< (mbe_pkg::WORD_W - 1)) - 1;
	localparam longint WORD_MIN = -(64'sd1 <<< (mbe_pkg::WORD_W - 1));
	localparam int PHASES = 12;
	localparam int PIXELS_PER_PHASE = 152;
	localparam int MAX_SHOWN = 10;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [mbe_pkg::PIX_W-1:0]   pixel_x = '0;
	logic [mbe_pkg::PIX_W-1:0]   pixel_y = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [mbe_pkg::COUNT_W-1:0] escape_count;
	logic                        cfg_we = 1'b0;
	logic [mbe_pkg::IDX_W-1:0]   cfg_index = '0;
	logic [mbe_pkg::WORD_W-1:0]  cfg_data = '0;

	// Shadow of the register file, updated at each write
	mbe_pkg::mbe_cfg_t regs;
	// Predicted escape counts of pixels in flight, oldest first
	logic [mbe_pkg::COUNT_W-1:0] expected_counts[$];
	logic [mbe_pkg::COUNT_W-1:0] expected_now;
	// High while neither side may idle
	logic steady = 1'b0;
	int mismatches = 0;
	int pixels_sent = 0;
	int reg_writes = 0;

	mandelbrot_escape_time uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.escape_count(escape_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Clamp to the signed coordinate word range.
	function automatic longint clamp_word(input longint v);
		if (v > WORD_MAX)
			return WORD_MAX;
		if (v < WORD_MIN)
			return WORD_MIN;
		return v;
	endfunction

	// Escape index of one pixel under the current register shadow.
	function automatic logic [mbe_pkg::COUNT_W-1:0] escape_index(
			input logic [mbe_pkg::PIX_W-1:0] x, input logic [mbe_pkg::PIX_W-1:0] y);
		longint cr, ci, re, im, re_next;
		longint unsigned mag_sq;
		logic [mbe_pkg::COUNT_W-1:0] count;
		int i;
		count = '0;
		re = 0;
		im = 0;
		if (x >= mbe_pkg::DEF_MAX_WIDTH || y >= mbe_pkg::DEF_MAX_HEIGHT)
			return count;
		cr = clamp_word(longint'($signed(regs.origin_real))
			+ longint'(x) * longint'(regs.step_real));
		ci = clamp_word(longint'($signed(regs.origin_imag))
			- longint'(y) * longint'(regs.step_imag));
		for (i = 0; i < regs.max_iterations; i++) begin
			// exact test: each square fits 63 bits, the sum wraps cleanly into 64 unsigned
			mag_sq = re * re + im * im;
			if (mag_sq > ESCAPE_RADIUS_SQ) begin
				count = mbe_pkg::COUNT_W'(i);
				break;
			end
			// floor rescale back to FRAC fraction bits, then saturate
			re_next = clamp_word(((re * re - im * im) >>> FRAC) + cr);
			im = clamp_word(((re * im) >>> (FRAC - 1)) + ci);
			re = re_next;
		end
		return count;
	endfunction

	// Receiver: stall about 35 percent of the time unless steady.
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 35);

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: escape_count %0d arrived with no pixel pending",
						$time, escape_count);
			end else begin
				expected_now = expected_counts.pop_front();
				if (escape_count !== expected_now) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: escape_count expected %0d, got %0d",
							$time, expected_now, escape_count);
				end
			end
		end
	end

	// Present one pixel word, hold it until accepted, then queue its prediction.
	// Valid is only dropped on an idle cycle, so back-to-back words keep it high.
	task automatic send_pixel(input logic [mbe_pkg::PIX_W-1:0] x,
			input logic [mbe_pkg::PIX_W-1:0] y);
		if (!steady)
			while ($urandom_range(99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_counts.push_back(escape_index(x, y));
		pixels_sent++;
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_counts.size() != 0)
			@(posedge clk);
	endtask

	// One register write; the strobe is lowered on a separate edge.
	task automatic write_reg(input logic [mbe_pkg::IDX_W-1:0] idx,
			input logic [mbe_pkg::WORD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			mbe_pkg::REG_ORIGIN_REAL:    regs.origin_real = value;
			mbe_pkg::REG_ORIGIN_IMAG:    regs.origin_imag = value;
			mbe_pkg::REG_STEP_REAL:      regs.step_real = value[mbe_pkg::STEP_W-1:0];
			mbe_pkg::REG_STEP_IMAG:      regs.step_imag = value[mbe_pkg::STEP_W-1:0];
			mbe_pkg::REG_MAX_ITERATIONS: regs.max_iterations = value[mbe_pkg::COUNT_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Drain, then load all five registers.
	task automatic configure(input logic [mbe_pkg::WORD_W-1:0] re0,
			input logic [mbe_pkg::WORD_W-1:0] im0,
			input logic [mbe_pkg::STEP_W-1:0] re_step,
			input logic [mbe_pkg::STEP_W-1:0] im_step,
			input logic [mbe_pkg::COUNT_W-1:0] limit);
		wait_idle();
		write_reg(mbe_pkg::REG_ORIGIN_REAL, re0);
		write_reg(mbe_pkg::REG_ORIGIN_IMAG, im0);
		write_reg(mbe_pkg::REG_STEP_REAL, mbe_pkg::WORD_W'(re_step));
		write_reg(mbe_pkg::REG_STEP_IMAG, mbe_pkg::WORD_W'(im_step));
		write_reg(mbe_pkg::REG_MAX_ITERATIONS, mbe_pkg::WORD_W'(limit));
	endtask

	// Image corners and a few inner points with the power-on settings.
	task automatic test_reset_defaults();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd683, 12'd1365);
		send_pixel(12'd1000, 12'd2048);
	endtask

	// A zero limit makes no test at all; a limit of one only tests z = 0.
	task automatic test_zero_limit();
		configure(mbe_pkg::RST_ORIGIN_REAL, mbe_pkg::RST_ORIGIN_IMAG, mbe_pkg::RST_STEP_REAL,
			mbe_pkg::RST_STEP_IMAG, '0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd2048);
		configure(mbe_pkg::RST_ORIGIN_REAL, mbe_pkg::RST_ORIGIN_IMAG, mbe_pkg::RST_STEP_REAL,
			mbe_pkg::RST_STEP_IMAG, 16'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
	endtask

	// Points that stay bounded, and one that leaves at the first step.
	task automatic test_bounded_points();
		// c = 0 runs the full 16-bit limit and never escapes
		configure('0, '0, '0, '0, 16'hFFFF);
		send_pixel(12'd4095, 12'd4095);
		// largest real origin leaves at once
		configure(32'h7FFF_FFFF, '0, '0, '0, 16'hFFFF);
		send_pixel(12'd0, 12'd0);
		// c = -2 settles at z = 2, where |z|^2 equals 4 exactly and must not count
		configure(32'hE000_0000, '0, '0, '0, 16'd1000);
		send_pixel(12'd123, 12'd4095);
	endtask

	// Origins at the word limits with full-size steps push c past the range.
	task automatic test_saturation();
		configure(32'h7FFF_FFFF, 32'h8000_0000, mbe_pkg::STEP_W'(1 << FRAC),
			mbe_pkg::STEP_W'(1 << FRAC), 16'hFFFF);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		configure(32'h8000_0000, 32'h7FFF_FFFF, mbe_pkg::STEP_W'(1 << FRAC),
			mbe_pkg::STEP_W'(1 << FRAC), 16'd300);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		// origin plus eight full steps lands right next to c = 0
		send_pixel(12'd8, 12'd8);
	endtask

	// Random frames: mostly views around the set, some with arbitrary registers.
	task automatic test_random_frames();
		logic [mbe_pkg::WORD_W-1:0] re0, im0;
		logic [mbe_pkg::STEP_W-1:0] re_step, im_step;
		logic [mbe_pkg::COUNT_W-1:0] limit;
		int phase, n;
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase % 4 == 3) begin
				re0 = $urandom();
				im0 = $urandom();
				re_step = mbe_pkg::STEP_W'($urandom_range(0, 1 << FRAC));
				im_step = mbe_pkg::STEP_W'($urandom_range(0, 1 << FRAC));
			end else begin
				// real in [-2.5, 0.5], imaginary in [-1.5, 1.5]
				re0 = $urandom_range(0, 3 << FRAC) - (5 << (FRAC - 1));
				im0 = $urandom_range(0, 3 << FRAC) - (3 << (FRAC - 1));
				re_step = mbe_pkg::STEP_W'($urandom_range(0, 1 << 18));
				im_step = mbe_pkg::STEP_W'($urandom_range(0, 1 << 18));
			end
			limit = (phase % 5 == 4) ? mbe_pkg::COUNT_W'($urandom_range(150, 300))
				: mbe_pkg::COUNT_W'($urandom_range(0, 48));
			configure(re0, im0, re_step, im_step, limit);
			// one whole frame runs with neither side idling
			steady = (phase == 6);
			for (n = 0; n < PIXELS_PER_PHASE; n++)
				send_pixel(mbe_pkg::PIX_W'($urandom_range(0, 4095)),
					mbe_pkg::PIX_W'($urandom_range(0, 4095)));
			wait_idle();
		end
		steady = 1'b0;
	endtask

	initial begin
		regs = '{mbe_pkg::RST_ORIGIN_REAL, mbe_pkg::RST_ORIGIN_IMAG, mbe_pkg::RST_STEP_REAL,
			mbe_pkg::RST_STEP_IMAG, mbe_pkg::RST_MAX_ITERATIONS};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_limit();
		test_bounded_points();
		test_saturation();
		test_random_frames();
		wait_idle();
		// let any stray word surface before the verdict
		repeat (16) @(posedge clk);
		$display("Ran %0d pixels through %0d register writes: image corners, zero and full limits,",
			pixels_sent, reg_writes);
		$display("the |z|^2 = 4 boundary, saturated c and %0d random frames.", PHASES);
		if (mismatches == 0 && expected_counts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
